@@ sv/bmo_pkg.sv @@
// Bicycle-model odometry: shared types, register codes, widths and constants.
// Used by bmo_div and bicycle_model_odometry; depends on nothing else.
package bmo_pkg;

   localparam int POS_FRAC_BITS = 12;
   localparam int CORDIC_STEPS  = 24;

   // shared divider: numerator and divisor widths
   localparam int DIV_NW = 60;
   localparam int DIV_DW = 42;
   localparam int DIV_CW = $clog2(DIV_NW);

   // CORDIC datapath width
   localparam int CRD_W = 34;

   localparam logic [DIV_DW-1:0] POS_DIV  = DIV_DW'(64'd1000000 << (24 - POS_FRAC_BITS));
   localparam logic [DIV_DW-1:0] HEAD_DIV = DIV_DW'(25132741);
   localparam logic signed [CRD_W-1:0] CORDIC_GAIN = CRD_W'(652032874);

   // register indexes
   localparam logic [2:0] CSR_STEER_RATIO   = 3'd0;
   localparam logic [2:0] CSR_WHEEL_BASE    = 3'd1;
   localparam logic [2:0] CSR_DEADBAND      = 3'd2;
   localparam logic [2:0] CSR_DEADBAND_VAL  = 3'd3;
   localparam logic [2:0] CSR_START_X       = 3'd4;
   localparam logic [2:0] CSR_START_Y       = 3'd5;
   localparam logic [2:0] CSR_START_HEADING = 3'd6;

   localparam logic [15:0]        RST_STEER_RATIO   = 16'd11008;
   localparam logic [15:0]        RST_WHEEL_BASE    = 16'd7229;
   localparam logic [17:0]        RST_DEADBAND      = 18'd2432;
   localparam logic signed [18:0] RST_DEADBAND_VAL  = -19'sd256;
   localparam logic signed [31:0] RST_START_X       = -32'sd7382;
   localparam logic signed [31:0] RST_START_Y       = -32'sd1105289;
   localparam logic [31:0]        RST_START_HEADING = 32'd0;

   typedef struct packed {
      logic signed [18:0] steer_angle;
      logic signed [15:0] speed_kmh;
      logic [19:0]        elapsed_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        heading;
      logic signed [15:0] speed_mps;
      logic signed [15:0] yaw_rate;
   } rsp_type;

   // arctan(2^-i) as a binary angle, full turn 2^32
   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] r;
      case (idx)
         5'd0:  r = 30'd536870912;
         5'd1:  r = 30'd316933406;
         5'd2:  r = 30'd167458907;
         5'd3:  r = 30'd85004756;
         5'd4:  r = 30'd42667331;
         5'd5:  r = 30'd21354465;
         5'd6:  r = 30'd10679838;
         5'd7:  r = 30'd5340245;
         5'd8:  r = 30'd2670163;
         5'd9:  r = 30'd1335087;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41722;
         5'd15: r = 30'd20861;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2608;
         5'd19: r = 30'd1304;
         5'd20: r = 30'd652;
         5'd21: r = 30'd326;
         5'd22: r = 30'd163;
         5'd23: r = 30'd81;
         5'd24: r = 30'd41;
         5'd25: r = 30'd20;
         5'd26: r = 30'd10;
         5'd27: r = 30'd5;
         5'd28: r = 30'd3;
         5'd29: r = 30'd1;
         5'd30: r = 30'd1;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

@@ sv/bmo_div.sv @@
// Bicycle-model odometry: shared radix-2 restoring divider, one quotient bit a cycle.
// Depends on bmo_pkg for the operand widths.
module bmo_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bmo_pkg::DIV_NW-1:0]  numer,
   input  logic [bmo_pkg::DIV_DW-1:0]  denom,
   output logic                        done,
   output logic [bmo_pkg::DIV_NW-1:0]  quot
);

   logic [bmo_pkg::DIV_NW-1:0] n_ff, n_in;
   logic [bmo_pkg::DIV_DW-1:0] d_ff, d_in;
   logic [bmo_pkg::DIV_DW-1:0] rem_ff, rem_in;
   logic [bmo_pkg::DIV_CW-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [bmo_pkg::DIV_DW:0]   cand, diff;
   logic                       ge;

   always_comb begin
      cand = {rem_ff, n_ff[bmo_pkg::DIV_NW-1]};
      diff = cand - {1'b0, d_ff};
      ge   = (cand >= {1'b0, d_ff});
      n_in    = n_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = numer;
         d_in    = denom;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // quotient bits shift in behind the numerator
         n_in   = {n_ff[bmo_pkg::DIV_NW-2:0], ge};
         rem_in = ge ? diff[bmo_pkg::DIV_DW-1:0] : cand[bmo_pkg::DIV_DW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bmo_pkg::DIV_CW'(bmo_pkg::DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff   <= n_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = n_ff;

endmodule

@@ sv/bicycle_model_odometry.sv @@
// Bicycle-model dead reckoning: one result per transfer. Each request makes six passes
// through the shared 60-step divider (the yaw-rate division is skipped for a zero
// numerator or zero cosine) plus two 24-step CORDIC runs; the next request is taken
// in the cycle the result turns valid, or later if the previous result still waits
// when this one is finished.
// Synchronous active-high reset: control cleared, registers and pose to defaults.
// Depends on bmo_pkg and bmo_div.
module bicycle_model_odometry (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bmo_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bmo_pkg::rsp_type    rsp_data,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wr_data
);

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_V_DIV     = 5'd1;
   localparam logic [4:0] ST_V_WAIT    = 5'd2;
   localparam logic [4:0] ST_ANG_DIV   = 5'd3;
   localparam logic [4:0] ST_ANG_WAIT  = 5'd4;
   localparam logic [4:0] ST_CR_ROAD   = 5'd5;
   localparam logic [4:0] ST_TAN1      = 5'd6;
   localparam logic [4:0] ST_TAN2      = 5'd7;
   localparam logic [4:0] ST_TAN3      = 5'd8;
   localparam logic [4:0] ST_RATE_DIV  = 5'd9;
   localparam logic [4:0] ST_RATE_WAIT = 5'd10;
   localparam logic [4:0] ST_HEAD_LOAD = 5'd11;
   localparam logic [4:0] ST_CR_HEAD   = 5'd12;
   localparam logic [4:0] ST_MX1       = 5'd13;
   localparam logic [4:0] ST_MX2       = 5'd14;
   localparam logic [4:0] ST_MX3       = 5'd15;
   localparam logic [4:0] ST_X_WAIT    = 5'd16;
   localparam logic [4:0] ST_MY1       = 5'd17;
   localparam logic [4:0] ST_MY2       = 5'd18;
   localparam logic [4:0] ST_MY3       = 5'd19;
   localparam logic [4:0] ST_Y_WAIT    = 5'd20;
   localparam logic [4:0] ST_H1        = 5'd21;
   localparam logic [4:0] ST_H2        = 5'd22;
   localparam logic [4:0] ST_H_WAIT    = 5'd23;
   localparam logic [4:0] ST_DONE      = 5'd24;

   localparam int CW = bmo_pkg::CRD_W;
   localparam int NW = bmo_pkg::DIV_NW;
   localparam int DW = bmo_pkg::DIV_DW;

   logic [4:0]               state_ff, state_in;
   logic signed [18:0]       steer_ff, steer_in;
   logic signed [15:0]       spd_ff, spd_in;
   logic [19:0]              dt_ff, dt_in;
   logic [15:0]              v_mag_ff, v_mag_in;
   logic signed [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic                     cflip_ff, cflip_in;
   logic [4:0]               cidx_ff, cidx_in;
   logic [65:0]              prod_ff, prod_in;
   logic [57:0]              mn_ff, mn_in;
   logic [41:0]              md_ff, md_in;
   logic                     rneg_ff, rneg_in;
   logic [15:0]              rate_mag_ff, rate_mag_in;
   logic                     xneg_ff, xneg_in, yneg_ff, yneg_in;
   logic [33:0]              dx_ff, dx_in, dy_ff, dy_in;
   logic [31:0]              dth_ff, dth_in;
   logic signed [31:0]       pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [31:0]              head_ff, head_in;
   logic [15:0]              ratio_ff, ratio_in, base_ff, base_in;
   logic [17:0]              dband_ff, dband_in;
   logic signed [18:0]       dval_ff, dval_in;
   bmo_pkg::rsp_type         rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     div_start, div_done;
   logic [NW-1:0]            div_n, div_q;
   logic [DW-1:0]            div_d;
   logic [33:0]              mul_a;
   logic [31:0]              mul_b;

   logic [18:0]              in_mag, steer_mag;
   logic [15:0]              spd_mag;
   logic                     v_neg;
   logic [15:0]              ratio_eff, base_eff;
   logic [DW-1:0]            ang_d;
   logic [31:0]              road;
   logic                     cload;
   logic [31:0]              cang, cang_f;
   logic signed [CW-1:0]     ctx, cty, catan;
   logic [CW-1:0]            x_mag, y_mag;
   logic [25:0]              s_mag, c_mag;
   logic                     s_neg, c_neg;
   logic [33:0]              t_mag;
   logic signed [35:0]       nx, ny, sx, sy, dxs, dys;
   logic signed [31:0]       nx_sat, ny_sat;
   logic [31:0]              head_new;
   logic [15:0]              spd_out, yaw_out;

   function automatic logic [15:0] rate_cap(input logic [NW-1:0] q, input logic neg);
      logic [15:0] r;
      if (neg)
         r = (q > NW'(32768)) ? 16'd32768 : q[15:0];
      else
         r = (q > NW'(32767)) ? 16'd32767 : q[15:0];
      return r;
   endfunction

   bmo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_n),
      .denom (div_d),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      in_mag    = req_data.steer_angle[18] ? 19'(-req_data.steer_angle)
                                           : 19'(req_data.steer_angle);
      steer_mag = steer_ff[18] ? 19'(-steer_ff) : 19'(steer_ff);
      spd_mag   = spd_ff[15] ? 16'(-spd_ff) : 16'(spd_ff);
      v_neg     = spd_ff[15];
      ratio_eff = (ratio_ff == 16'd0) ? 16'd1 : ratio_ff;
      base_eff  = (base_ff == 16'd0) ? 16'd1 : base_ff;
      ang_d     = DW'(ratio_eff * 25'd360);
      road      = steer_ff[18] ? 32'(-div_q[31:0]) : div_q[31:0];

      // CORDIC step, shift by the iteration index
      ctx   = cx_ff >>> cidx_ff;
      cty   = cy_ff >>> cidx_ff;
      catan = CW'(bmo_pkg::atan_entry(cidx_ff));
      x_mag = cx_ff[CW-1] ? CW'(-cx_ff) : CW'(cx_ff);
      y_mag = cy_ff[CW-1] ? CW'(-cy_ff) : CW'(cy_ff);
      s_mag = 26'((y_mag + CW'(32)) >> 6);
      c_mag = 26'((x_mag + CW'(32)) >> 6);
      s_neg = cy_ff[CW-1] ^ cflip_ff;
      c_neg = (cx_ff[CW-1] ^ cflip_ff) && (c_mag != 26'd0);
      t_mag = 34'((prod_ff[47:0] + 48'd8192) >> 14);

      sx  = 36'(pos_x_ff);
      sy  = 36'(pos_y_ff);
      dxs = signed'({2'b00, dx_ff});
      dys = signed'({2'b00, dy_ff});
      nx  = xneg_ff ? sx + dxs : sx - dxs;
      ny  = yneg_ff ? sy - dys : sy + dys;
      nx_sat = (nx > 36'sd2147483647) ? 32'sh7fffffff :
               (nx < -36'sd2147483648) ? 32'sh80000000 : 32'(nx);
      ny_sat = (ny > 36'sd2147483647) ? 32'sh7fffffff :
               (ny < -36'sd2147483648) ? 32'sh80000000 : 32'(ny);
      head_new = rneg_ff ? head_ff - dth_ff : head_ff + dth_ff;
      if (v_neg)
         spd_out = (v_mag_ff > 16'd32768) ? 16'h8000 : 16'(-v_mag_ff);
      else
         spd_out = (v_mag_ff > 16'd32767) ? 16'h7fff : v_mag_ff;
      yaw_out = rneg_ff ? 16'(-rate_mag_ff) : rate_mag_ff;
   end

   always_comb begin
      state_in    = state_ff;
      steer_in    = steer_ff;
      spd_in      = spd_ff;
      dt_in       = dt_ff;
      v_mag_in    = v_mag_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      cz_in       = cz_ff;
      cflip_in    = cflip_ff;
      cidx_in     = cidx_ff;
      mn_in       = mn_ff;
      md_in       = md_ff;
      rneg_in     = rneg_ff;
      rate_mag_in = rate_mag_ff;
      xneg_in     = xneg_ff;
      yneg_in     = yneg_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      dth_in      = dth_ff;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      head_in     = head_ff;
      ratio_in    = ratio_ff;
      base_in     = base_ff;
      dband_in    = dband_ff;
      dval_in     = dval_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_start   = 1'b0;
      div_n       = '0;
      div_d       = '0;
      mul_a       = '0;
      mul_b       = '0;
      cload       = 1'b0;
      cang        = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               steer_in = (in_mag <= {1'b0, dband_ff}) ? dval_ff : req_data.steer_angle;
               spd_in   = req_data.speed_kmh;
               dt_in    = req_data.elapsed_time;
               state_in = ST_V_DIV;
            end
         end
         ST_V_DIV: begin
            div_start = 1'b1;
            div_n     = NW'(spd_mag * 20'd10) + NW'(4);
            div_d     = DW'(9);
            state_in  = ST_V_WAIT;
         end
         ST_V_WAIT: begin
            if (div_done) begin
               v_mag_in = div_q[15:0];
               state_in = ST_ANG_DIV;
            end
         end
         ST_ANG_DIV: begin
            div_start = 1'b1;
            div_d     = ang_d;
            div_n     = NW'({steer_mag, 32'd0}) + NW'(ang_d >> 1);
            state_in  = ST_ANG_WAIT;
         end
         ST_ANG_WAIT: begin
            if (div_done) begin
               cload    = 1'b1;
               cang     = road;
               state_in = ST_CR_ROAD;
            end
         end
         ST_CR_ROAD, ST_CR_HEAD: begin
            if (!cz_ff[CW-1]) begin
               cx_in = cx_ff - cty;
               cy_in = cy_ff + ctx;
               cz_in = cz_ff - catan;
            end else begin
               cx_in = cx_ff + cty;
               cy_in = cy_ff - ctx;
               cz_in = cz_ff + catan;
            end
            cidx_in = cidx_ff + 1'b1;
            if (cidx_ff == 5'(bmo_pkg::CORDIC_STEPS - 1)) begin
               cx_in    = cx_ff;
               cy_in    = cy_ff;
               cz_in    = cz_ff;
               cidx_in  = cidx_ff;
               // the last step is applied below to x and y only; z and the index hold
               state_in = (state_ff == ST_CR_ROAD) ? ST_TAN1 : ST_MX1;
               if (!cz_ff[CW-1]) begin
                  cx_in = cx_ff - cty;
                  cy_in = cy_ff + ctx;
               end else begin
                  cx_in = cx_ff + cty;
                  cy_in = cy_ff - ctx;
               end
            end
         end
         ST_TAN1: begin
            mul_a    = 34'(v_mag_ff);
            mul_b    = 32'(s_mag);
            state_in = ST_TAN2;
         end
         ST_TAN2: begin
            mn_in    = {prod_ff[41:0], 16'd0};
            rneg_in  = v_neg ^ s_neg ^ c_neg;
            mul_a    = 34'(c_mag);
            mul_b    = 32'(base_eff);
            state_in = ST_TAN3;
         end
         ST_TAN3: begin
            md_in    = prod_ff[41:0];
            state_in = ST_RATE_DIV;
         end
         ST_RATE_DIV: begin
            if (mn_ff == 58'd0) begin
               rate_mag_in = 16'd0;
               state_in    = ST_HEAD_LOAD;
            end else if (md_ff == 42'd0) begin
               rate_mag_in = rate_cap(NW'(32768), rneg_ff);
               state_in    = ST_HEAD_LOAD;
            end else begin
               div_start = 1'b1;
               div_n     = NW'(mn_ff) + NW'(md_ff >> 1);
               div_d     = md_ff;
               state_in  = ST_RATE_WAIT;
            end
         end
         ST_RATE_WAIT: begin
            if (div_done) begin
               rate_mag_in = rate_cap(div_q, rneg_ff);
               state_in    = ST_HEAD_LOAD;
            end
         end
         ST_HEAD_LOAD: begin
            cload    = 1'b1;
            cang     = head_ff;
            state_in = ST_CR_HEAD;
         end
         ST_MX1: begin
            xneg_in  = v_neg ^ s_neg;
            yneg_in  = v_neg ^ cx_ff[CW-1] ^ cflip_ff;
            mul_a    = 34'(v_mag_ff);
            mul_b    = y_mag[31:0];
            state_in = ST_MX2;
         end
         ST_MX2, ST_MY2: begin
            mul_a    = t_mag;
            mul_b    = 32'(dt_ff);
            state_in = (state_ff == ST_MX2) ? ST_MX3 : ST_MY3;
         end
         ST_MX3, ST_MY3: begin
            div_start = 1'b1;
            div_n     = NW'(prod_ff[53:0]) + NW'(bmo_pkg::POS_DIV >> 1);
            div_d     = bmo_pkg::POS_DIV;
            state_in  = (state_ff == ST_MX3) ? ST_X_WAIT : ST_Y_WAIT;
         end
         ST_X_WAIT: begin
            if (div_done) begin
               dx_in    = div_q[33:0];
               state_in = ST_MY1;
            end
         end
         ST_MY1: begin
            mul_a    = 34'(v_mag_ff);
            mul_b    = x_mag[31:0];
            state_in = ST_MY2;
         end
         ST_Y_WAIT: begin
            if (div_done) begin
               dy_in    = div_q[33:0];
               state_in = ST_H1;
            end
         end
         ST_H1: begin
            mul_a    = 34'(rate_mag_ff);
            mul_b    = 32'(dt_ff);
            state_in = ST_H2;
         end
         ST_H2: begin
            div_start = 1'b1;
            div_n     = NW'({prod_ff[35:0], 22'd0}) + NW'(bmo_pkg::HEAD_DIV >> 1);
            div_d     = bmo_pkg::HEAD_DIV;
            state_in  = ST_H_WAIT;
         end
         ST_H_WAIT: begin
            if (div_done) begin
               dth_in   = div_q[31:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               pos_x_in         = nx_sat;
               pos_y_in         = ny_sat;
               head_in          = head_new;
               rsp_in.pos_x     = nx_sat;
               rsp_in.pos_y     = ny_sat;
               rsp_in.heading   = head_new;
               rsp_in.speed_mps = spd_out;
               rsp_in.yaw_rate  = yaw_out;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // quadrants two and three are folded by a half turn
      cang_f = (cang[31] ^ cang[30]) ? {~cang[31], cang[30:0]} : cang;
      if (cload) begin
         cx_in    = bmo_pkg::CORDIC_GAIN;
         cy_in    = '0;
         cz_in    = CW'(signed'(cang_f));
         cflip_in = cang[31] ^ cang[30];
         cidx_in  = '0;
      end

      if (csr_wr_en) begin
         case (csr_index)
            bmo_pkg::CSR_STEER_RATIO:   ratio_in = csr_wr_data[15:0];
            bmo_pkg::CSR_WHEEL_BASE:    base_in  = csr_wr_data[15:0];
            bmo_pkg::CSR_DEADBAND:      dband_in = csr_wr_data[17:0];
            bmo_pkg::CSR_DEADBAND_VAL:  dval_in  = signed'(csr_wr_data[18:0]);
            bmo_pkg::CSR_START_X:       pos_x_in = signed'(csr_wr_data);
            bmo_pkg::CSR_START_Y:       pos_y_in = signed'(csr_wr_data);
            bmo_pkg::CSR_START_HEADING: head_in  = csr_wr_data;
            default: ;
         endcase
      end
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ratio_ff     <= bmo_pkg::RST_STEER_RATIO;
         base_ff      <= bmo_pkg::RST_WHEEL_BASE;
         dband_ff     <= bmo_pkg::RST_DEADBAND;
         dval_ff      <= bmo_pkg::RST_DEADBAND_VAL;
         pos_x_ff     <= bmo_pkg::RST_START_X;
         pos_y_ff     <= bmo_pkg::RST_START_Y;
         head_ff      <= bmo_pkg::RST_START_HEADING;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ratio_ff     <= ratio_in;
         base_ff      <= base_in;
         dband_ff     <= dband_in;
         dval_ff      <= dval_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         head_ff      <= head_in;
      end
      steer_ff    <= steer_in;
      spd_ff      <= spd_in;
      dt_ff       <= dt_in;
      v_mag_ff    <= v_mag_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      cflip_ff    <= cflip_in;
      cidx_ff     <= cidx_in;
      prod_ff     <= prod_in;
      mn_ff       <= mn_in;
      md_ff       <= md_in;
      rneg_ff     <= rneg_in;
      rate_mag_ff <= rate_mag_in;
      xneg_ff     <= xneg_in;
      yneg_ff     <= yneg_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dth_ff      <= dth_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ dv/bmo_checker.sv @@
// Bicycle-model odometry checker: watches the request, response and register ports,
// predicts each pose update and compares it field by field. Depends on bmo_pkg.
`timescale 1ns / 100ps
module bmo_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  bmo_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  bmo_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wr_data,
   output int               fail_count,
   output int               pending
);

   logic [15:0]        ratio_q, base_q;
   logic [17:0]        dband_q;
   logic signed [18:0] dval_q;
   logic signed [31:0] pose_x, pose_y;
   logic [31:0]        pose_h;
   bmo_pkg::rsp_type   pose_fifo[$];

   localparam longint ATAN_LUT [0:23] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

   function automatic longint rdiv(input longint n, input longint d);
      longint m, q;
      m = (n < 0) ? -n : n;
      q = (m + d / 2) / d;
      return (n < 0) ? -q : q;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // rotation mode, result scaled by 2^30; quadrants 1 and 2 folded through pi
   task automatic rotate(input logic [31:0] a, output longint sn, output longint cs);
      logic   flip;
      longint x, y, z, tx, ty;
      flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
      if (flip) a = a - 32'h8000_0000;
      z = longint'($signed(a));
      x = 652032874;
      y = 0;
      for (int i = 0; i < bmo_pkg::CORDIC_STEPS; i++) begin
         tx = y >>> i;
         ty = x >>> i;
         if (z >= 0) begin
            x -= tx; y += ty; z -= ATAN_LUT[i];
         end else begin
            x += tx; y -= ty; z += ATAN_LUT[i];
         end
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
   endtask

   task automatic advance_pose(input bmo_pkg::req_type r, output bmo_pkg::rsp_type o);
      longint steer, spd, dt, ratio, base, v, ang, rs, rc, hs, hc, s24, c24;
      longint mn, md, q, rate, dx, dy, nx, ny, dth;
      logic   neg;
      steer = r.steer_angle;
      spd   = r.speed_kmh;
      dt    = longint'(r.elapsed_time);
      ratio = (ratio_q == 0) ? 1 : longint'(ratio_q);
      base  = (base_q == 0) ? 1 : longint'(base_q);
      if (((steer < 0) ? -steer : steer) <= longint'(dband_q)) steer = dval_q;
      v = rdiv(spd * 10, 9);
      ang = rdiv(steer * 64'sd4294967296, 360 * ratio);
      rotate(ang[31:0], rs, rc);
      s24 = rdiv(rs, 64);
      c24 = rdiv(rc, 64);
      mn = ((v < 0) ? -v : v) * ((s24 < 0) ? -s24 : s24) * 65536;
      md = ((c24 < 0) ? -c24 : c24) * base;
      neg = ((v < 0) != (s24 < 0)) != (c24 < 0);
      if (mn == 0) q = 0;
      else if (md == 0) q = 32768;
      else q = (mn + md / 2) / md;
      if (neg) rate = -((q > 32768) ? 32768 : q);
      else rate = (q > 32767) ? 32767 : q;
      // position uses the heading from before this transfer
      rotate(pose_h, hs, hc);
      dx = rdiv(rdiv(v * hs, 16384) * dt,
                64'sd1000000 << (24 - bmo_pkg::POS_FRAC_BITS));
      dy = rdiv(rdiv(v * hc, 16384) * dt,
                64'sd1000000 << (24 - bmo_pkg::POS_FRAC_BITS));
      nx = clamp(longint'(pose_x) - dx, -64'sd2147483648, 64'sd2147483647);
      ny = clamp(longint'(pose_y) + dy, -64'sd2147483648, 64'sd2147483647);
      pose_x = nx[31:0];
      pose_y = ny[31:0];
      dth = rdiv(rate * dt * 4194304, 25132741);
      pose_h = pose_h + dth[31:0];
      o.pos_x     = nx[31:0];
      o.pos_y     = ny[31:0];
      o.heading   = pose_h;
      o.speed_mps = 16'(clamp(v, -32768, 32767));
      o.yaw_rate  = rate[15:0];
   endtask

   always @(posedge clock) begin
      bmo_pkg::rsp_type exp_pose, got;
      if (reset) begin
         ratio_q = bmo_pkg::RST_STEER_RATIO;
         base_q  = bmo_pkg::RST_WHEEL_BASE;
         dband_q = bmo_pkg::RST_DEADBAND;
         dval_q  = bmo_pkg::RST_DEADBAND_VAL;
         pose_x  = bmo_pkg::RST_START_X;
         pose_y  = bmo_pkg::RST_START_Y;
         pose_h  = bmo_pkg::RST_START_HEADING;
         pose_fifo.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               bmo_pkg::CSR_STEER_RATIO:   ratio_q = csr_wr_data[15:0];
               bmo_pkg::CSR_WHEEL_BASE:    base_q  = csr_wr_data[15:0];
               bmo_pkg::CSR_DEADBAND:      dband_q = csr_wr_data[17:0];
               bmo_pkg::CSR_DEADBAND_VAL:  dval_q  = csr_wr_data[18:0];
               bmo_pkg::CSR_START_X:       pose_x  = csr_wr_data;
               bmo_pkg::CSR_START_Y:       pose_y  = csr_wr_data;
               bmo_pkg::CSR_START_HEADING: pose_h  = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (pose_fifo.size() == 0) begin
               $error("response transfer with no pose expected");
               fail_count++;
            end else begin
               exp_pose = pose_fifo.pop_front();
               if (got.pos_x !== exp_pose.pos_x) begin
                  $error("pos_x: expected %0d, got %0d", exp_pose.pos_x, got.pos_x);
                  fail_count++;
               end
               if (got.pos_y !== exp_pose.pos_y) begin
                  $error("pos_y: expected %0d, got %0d", exp_pose.pos_y, got.pos_y);
                  fail_count++;
               end
               if (got.heading !== exp_pose.heading) begin
                  $error("heading: expected %0d, got %0d", exp_pose.heading, got.heading);
                  fail_count++;
               end
               if (got.speed_mps !== exp_pose.speed_mps) begin
                  $error("speed_mps: expected %0d, got %0d",
                         exp_pose.speed_mps, got.speed_mps);
                  fail_count++;
               end
               if (got.yaw_rate !== exp_pose.yaw_rate) begin
                  $error("yaw_rate: expected %0d, got %0d", exp_pose.yaw_rate, got.yaw_rate);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            advance_pose(req_data, exp_pose);
            pose_fifo = {pose_fifo, exp_pose};
         end
      end
      pending = pose_fifo.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end

endmodule

@@ dv/tb_bicycle_model_odometry.sv @@
// Testbench top for bicycle_model_odometry: drives directed and random steering items
// across register settings and idle mixes; checking is done in bmo_checker.
`timescale 1ns / 100ps
module tb_bicycle_model_odometry;

   localparam int CYCLE_LIMIT = 6000000;
   localparam int PHASE_ITEMS = 420;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   bmo_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   bmo_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [2:0]       csr_index = '0;
   logic [31:0]      csr_wr_data = '0;
   int               fail_count, pending;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   longint           cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bicycle_model_odometry u_dut (.*);

   bmo_checker u_checker (.*);

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send(input bmo_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_fields(input int steer, input int spd, input int dt);
      bmo_pkg::req_type item;
      item.steer_angle  = 19'(steer);
      item.speed_kmh    = 16'(spd);
      item.elapsed_time = 20'(dt);
      send(item);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task automatic write_regs(input logic [31:0] ratio, input logic [31:0] base,
                             input logic [31:0] dband, input logic [31:0] dval,
                             input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] sh);
      logic [31:0] vals [0:6];
      vals = '{ratio, base, dband, dval, sx, sy, sh};
      for (int i = 0; i < 7; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= 3'(i);
         csr_wr_data <= vals[i];
         @(posedge clock);
      end
      // unused index must be ignored
      csr_index   <= 3'd7;
      csr_wr_data <= $urandom;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic bmo_pkg::req_type random_item();
      bmo_pkg::req_type item;
      int               pick;
      item.steer_angle  = 19'($urandom);
      item.speed_kmh    = 16'($urandom);
      item.elapsed_time = 20'($urandom);
      pick = $urandom_range(99);
      if (pick < 20) item.steer_angle = 19'($signed($urandom_range(0, 6000)) - 3000);
      else if (pick < 30) item.steer_angle = $urandom_range(1) ? 19'sh3FFFF : 19'sh40000;
      pick = $urandom_range(99);
      if (pick < 60) item.elapsed_time = 20'($urandom_range(0, 100000));
      else if (pick < 70) item.elapsed_time = $urandom_range(1) ? 20'hFFFFF : 20'h0;
      if ($urandom_range(99) < 10) item.speed_kmh = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      return item;
   endfunction

   task automatic random_phase(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         send(random_item());
         // hold off once mid-phase until everything is back
         if (i == PHASE_ITEMS / 2) drain();
      end
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, field extremes, deadband edges
      send_fields(0, 0, 0);
      send_fields(2432, 6400, 100000);
      send_fields(-2432, 6400, 100000);
      send_fields(2433, 6400, 100000);
      send_fields(-2433, -6400, 100000);
      send_fields(262143, 32767, 1048575);
      send_fields(-262144, -32768, 1048575);
      send_fields(262143, -32768, 1048575);
      send_fields(-262144, 32767, 0);
      send_fields(0, 32767, 1048575);
      send_fields(0, -32768, 1048575);
      drain();
      // unit ratio so that 90 degrees of steering is a right angle at the road wheel
      write_regs(256, 1, 0, 0, 32'h7FFF_F000, 32'h8000_1000, 32'h4000_0000);
      send_fields(23040, 32767, 1048575);
      send_fields(-23040, 32767, 1048575);
      send_fields(23040, 0, 1048575);
      send_fields(46080, -32768, 1048575);
      send_fields(0, 32767, 1048575);
      drain();
      // zero ratio and base act as one; position saturates
      write_regs(0, 0, 262143, 262143, 32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000);
      send_fields(100, 32767, 1048575);
      send_fields(-262144, 32767, 1048575);
      send_fields(5, -32768, 1048575);
      drain();

      write_regs(bmo_pkg::RST_STEER_RATIO, bmo_pkg::RST_WHEEL_BASE,
                 bmo_pkg::RST_DEADBAND, bmo_pkg::RST_DEADBAND_VAL,
                 bmo_pkg::RST_START_X, bmo_pkg::RST_START_Y,
                 bmo_pkg::RST_START_HEADING);
      random_phase(0, 0);
      write_regs(65535, 65535, 0, 32'h0004_0000, 0, 0, 32'hFFFF_FFFF);
      random_phase(88, 0);
      write_regs(1, 1, 262143, 32'h0003_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      random_phase(0, 88);
      write_regs($urandom_range(1, 65535), $urandom_range(1, 65535),
                 $urandom_range(0, 8000), $urandom, $urandom, $urandom, $urandom);
      random_phase(13, 13);

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/bmo_pkg.sv
sv/bmo_div.sv
sv/bicycle_model_odometry.sv
dv/bmo_checker.sv
dv/tb_bicycle_model_odometry.sv
